>>> rtl/asfd_pkg.sv
// ----------------------------------------------------------------------------
// asfd_pkg: shared types and constants for the ADC scan frame decoder
// Holds the converter address, the resolution codes, the register indexes
// and the packed item layouts.
// ----------------------------------------------------------------------------
package asfd_pkg;

    // Number of converter inputs that are scanned (2..4)
    localparam int unsigned CHANNEL_COUNT = 4;

    // Fixed part of the converter bus address (7 bits)
    localparam logic [6:0] BASE_ADDR = 7'h68;

    // Item widths
    localparam int unsigned S_TDATA_W = 40;   // 34 used bits, padded to bytes
    localparam int unsigned S_TUSER_W = 2;
    localparam int unsigned M_TDATA_W = 56;   // 54 used bits, padded to bytes
    localparam int unsigned M_TUSER_W = 2;
    localparam int unsigned SAMPLE_W  = 18;

    typedef logic [1:0]                 chan_t;
    typedef logic signed [SAMPLE_W-1:0] sample_t;

    // Resolution codes
    typedef enum logic [1:0] {
        FMT_12BIT = 2'd0,
        FMT_14BIT = 2'd1,
        FMT_16BIT = 2'd2,
        FMT_18BIT = 2'd3
    } data_format_t;

    // Register indexes on the configuration port
    typedef enum logic [1:0] {
        REG_DATA_FORMAT = 2'd0,
        REG_GAIN_SEL    = 2'd1,
        REG_DEVICE_ID   = 2'd2,
        REG_UNUSED      = 2'd3
    } cfg_index_t;

    // Request kinds
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    // One accepted input transaction
    typedef struct packed {
        logic  read_ok;
        logic  req_type;
        chan_t query_channel;
        logic [7:0] byte3;
        logic [7:0] byte2;
        logic [7:0] byte1;
        logic [7:0] byte0;
    } in_item_t;

endpackage

>>> rtl/adc_scan_frame_decoder.sv
// ----------------------------------------------------------------------------
// adc_scan_frame_decoder: round-robin scan control and read frame decode
// Issues config-byte writes for a four-input converter, decodes its read
// frames by resolution, keeps the last sample of every channel.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+-------------------------------
//  s_      | in        | s_tvalid/s_tready  | s_tdata bytes+query, s_tuser
//  m_      | out       | m_tvalid/m_tready  | m_tdata write+sample, m_tuser
//  cfg_    | in        | cfg_wr_en          | cfg_index, cfg_wdata
//
//  One transaction per cycle sustained while the output is not stalled; an
//  item passes the input register, then the result register. Decode, scan
//  advance and table write happen as an item moves from the first to the second.
//  Reset (aresetn low, synchronous) clears config, scan channel and the
//  four stored samples. A stalled output holds its result; one more item is
//  still taken into the input register, after which s_tready drops.
module adc_scan_frame_decoder (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Configuration write port
    input  logic                          cfg_wr_en,
    input  asfd_pkg::cfg_index_t          cfg_index,
    input  logic [1:0]                    cfg_wdata,
    // Input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // tdata: byte0[7:0], byte1[15:8], byte2[23:16], byte3[31:24],
    //        query_channel[33:32], zero pad[39:34]
    input  logic [asfd_pkg::S_TDATA_W-1:0] s_tdata,
    // tuser: req_type[0], read_ok[1]
    input  logic [asfd_pkg::S_TUSER_W-1:0] s_tuser,
    // Result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // tdata: write_addr[7:0], write_byte[15:8], sample_channel[17:16],
    //        sample_value[35:18], query_value[53:36], zero pad[55:54]
    output logic [asfd_pkg::M_TDATA_W-1:0] m_tdata,
    // tuser: write_valid[0], sample_valid[1]
    output logic [asfd_pkg::M_TUSER_W-1:0] m_tuser
);
    import asfd_pkg::*;

    localparam int unsigned CH_CNT_W = 3;
    localparam logic [CH_CNT_W-1:0] CH_LIMIT = CH_CNT_W'(CHANNEL_COUNT);

    // Configuration registers
    data_format_t data_format_reg;
    logic [1:0]   gain_sel_reg;
    logic [1:0]   device_id_reg;

    // Scan state and stored samples
    chan_t   cur_chan_reg, cur_chan_next;
    sample_t table_reg [CHANNEL_COUNT];

    // Input register
    logic     in_vld_reg;
    in_item_t in_item_reg;

    // Result register
    logic                 out_vld_reg;
    logic [M_TDATA_W-1:0] out_data_reg, out_data_next;
    logic [M_TUSER_W-1:0] out_user_reg, out_user_next;

    logic advance;
    logic s_accept;

    // Decode signals
    sample_t    dec_value;
    logic [7:0] dec_status;
    logic       wr_valid;
    logic       smp_valid;
    chan_t      smp_chan;
    sample_t    smp_value;
    logic       store_en;
    chan_t      query_idx;
    sample_t    query_val;
    logic [CH_CNT_W-1:0] chan_inc;
    logic [7:0] wr_addr;
    logic [7:0] wr_byte;

    assign advance  = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            data_format_reg <= FMT_12BIT;
            gain_sel_reg    <= 2'd0;
            device_id_reg   <= 2'd0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_DATA_FORMAT: data_format_reg <= data_format_t'(cfg_wdata);
                REG_GAIN_SEL:    gain_sel_reg    <= cfg_wdata;
                REG_DEVICE_ID:   device_id_reg   <= cfg_wdata;
                default:         ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_item_reg <= in_item_t'({s_tuser[1], s_tuser[0], s_tdata[33:0]});
        end
    end

    // Frame decode by resolution, sign extended to 18 bits
    always_comb begin
        dec_value  = '0;
        dec_status = in_item_reg.byte2;
        case (data_format_reg)
            FMT_12BIT: dec_value = sample_t'({{6{in_item_reg.byte0[3]}},
                                   in_item_reg.byte0[3:0], in_item_reg.byte1});
            FMT_14BIT: dec_value = sample_t'({{4{in_item_reg.byte0[5]}},
                                   in_item_reg.byte0[5:0], in_item_reg.byte1});
            FMT_16BIT: dec_value = sample_t'({{2{in_item_reg.byte0[7]}},
                                   in_item_reg.byte0, in_item_reg.byte1});
            FMT_18BIT: begin
                dec_value  = sample_t'({in_item_reg.byte0[1:0], in_item_reg.byte1,
                                        in_item_reg.byte2});
                dec_status = in_item_reg.byte3;
            end
            default: ;
        endcase
    end

    // Step control: start, good read, ready conversion
    always_comb begin
        wr_valid      = 1'b0;
        smp_valid     = 1'b0;
        smp_chan      = '0;
        smp_value     = '0;
        store_en      = 1'b0;
        cur_chan_next = cur_chan_reg;
        chan_inc      = {1'b0, cur_chan_reg} + 3'd1;
        if (in_item_reg.req_type == REQ_START) begin
            cur_chan_next = '0;
            wr_valid      = 1'b1;
        end else if (in_item_reg.read_ok) begin
            smp_chan  = dec_status[6:5];
            smp_value = dec_value;
            if (!dec_status[7]) begin
                store_en      = ({1'b0, smp_chan} < CH_LIMIT);
                smp_valid     = store_en;
                cur_chan_next = (chan_inc >= CH_LIMIT) ? '0 : chan_inc[1:0];
                wr_valid      = 1'b1;
            end
        end
    end

    // Query lookup, including this step's store
    always_comb begin
        query_idx = ({1'b0, in_item_reg.query_channel} < CH_LIMIT) ?
                    in_item_reg.query_channel : '0;
        if (store_en && (smp_chan == query_idx)) begin
            query_val = smp_value;
        end else begin
            query_val = table_reg[query_idx];
        end
    end

    // Config byte write fields
    always_comb begin
        wr_addr = '0;
        wr_byte = '0;
        if (wr_valid) begin
            wr_addr = {BASE_ADDR | {5'd0, device_id_reg}, 1'b0};
            wr_byte = {1'b1, cur_chan_next, 1'b0, data_format_reg, gain_sel_reg};
        end
        out_data_next = {2'b00, query_val, smp_value, smp_chan, wr_byte, wr_addr};
        out_user_next = {smp_valid, wr_valid};
    end

    // Scan state and sample table update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_chan_reg <= '0;
            for (int i = 0; i < CHANNEL_COUNT; i++) begin
                table_reg[i] <= '0;
            end
        end else if (advance) begin
            cur_chan_reg <= cur_chan_next;
            if (store_en) begin
                table_reg[smp_chan] <= smp_value;
            end
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (advance) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= out_data_next;
            out_user_reg <= out_user_next;
        end
    end

endmodule

>>> test/asfd_checker.sv
// ----------------------------------------------------------------------------
// asfd_checker: result checker for the ADC scan frame decoder
// Watches the configuration port and both stream channels. For every input
// transaction it decodes the frame, advances the scan and updates the stored
// samples on its own copy of the state, then queues the expected result.
// Every result transaction is compared field by field with the oldest entry.
// ----------------------------------------------------------------------------
module asfd_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  asfd_pkg::cfg_index_t           cfg_index,
    input  logic [1:0]                     cfg_wdata,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    // tdata: byte0, byte1, byte2, byte3, query_channel, zero pad
    input  logic [asfd_pkg::S_TDATA_W-1:0] s_tdata,
    // tuser: req_type, read_ok
    input  logic [asfd_pkg::S_TUSER_W-1:0] s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    // tdata: write_addr, write_byte, sample_channel, sample_value, query_value, pad
    input  logic [asfd_pkg::M_TDATA_W-1:0] m_tdata,
    // tuser: write_valid, sample_valid
    input  logic [asfd_pkg::M_TUSER_W-1:0] m_tuser,
    output int                             fail_count,
    output int                             outstanding
);
    import asfd_pkg::*;

    typedef struct packed {
        logic       write_valid;
        logic [7:0] write_addr;
        logic [7:0] write_byte;
        logic       sample_valid;
        chan_t      sample_channel;
        sample_t    sample_value;
        sample_t    query_value;
    } scan_result_t;

    // Shadow configuration and state
    data_format_t fmt_r;
    logic [1:0]   gain_r;
    logic [1:0]   dev_r;
    chan_t        scan_ch;
    sample_t      stored [4];

    scan_result_t due_results [$];

    // Decode one input transaction, update scan state and sample store
    function automatic scan_result_t decode_and_scan(logic req, logic ok,
                                                     logic [7:0] b0, logic [7:0] b1,
                                                     logic [7:0] b2, logic [7:0] b3,
                                                     chan_t q);
        scan_result_t      r;
        logic [7:0]        status;
        logic signed [11:0] v12;
        logic signed [13:0] v14;
        logic signed [15:0] v16;
        logic signed [17:0] v18;
        r = '0;
        if (req == REQ_START) begin
            scan_ch = '0;
            r.write_valid = 1'b1;
        end else if (ok) begin
            case (fmt_r)
                FMT_12BIT: begin
                    v12 = {b0[3:0], b1};
                    r.sample_value = v12;
                    status = b2;
                end
                FMT_14BIT: begin
                    v14 = {b0[5:0], b1};
                    r.sample_value = v14;
                    status = b2;
                end
                FMT_16BIT: begin
                    v16 = {b0, b1};
                    r.sample_value = v16;
                    status = b2;
                end
                default: begin
                    v18 = {b0[1:0], b1, b2};
                    r.sample_value = v18;
                    status = b3;
                end
            endcase
            r.sample_channel = status[6:5];
            // ready bit clear: conversion done
            if (!status[7]) begin
                if (r.sample_channel < CHANNEL_COUNT) begin
                    stored[r.sample_channel] = r.sample_value;
                    r.sample_valid = 1'b1;
                end
                scan_ch = (int'(scan_ch) + 1 >= CHANNEL_COUNT) ? chan_t'(0) : scan_ch + 1'b1;
                r.write_valid = 1'b1;
            end
        end
        if (r.write_valid) begin
            r.write_addr = {BASE_ADDR | {5'b0, dev_r}, 1'b0};
            r.write_byte = {1'b1, scan_ch, 1'b0, fmt_r, gain_r};
        end
        r.query_value = stored[(q < CHANNEL_COUNT) ? q : chan_t'(0)];
        return r;
    endfunction

    task automatic check_field(string name, logic signed [31:0] want,
                               logic signed [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    // Shadow state, prediction and comparison
    always @(posedge aclk) begin
        scan_result_t want, got;
        if (!aresetn) begin
            fmt_r   <= FMT_12BIT;
            gain_r  <= '0;
            dev_r   <= '0;
            scan_ch = '0;
            for (int i = 0; i < 4; i++) stored[i] = '0;
            due_results.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_DATA_FORMAT: fmt_r  <= data_format_t'(cfg_wdata);
                    REG_GAIN_SEL:    gain_r <= cfg_wdata;
                    REG_DEVICE_ID:   dev_r  <= cfg_wdata;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got.write_valid    = m_tuser[0];
                got.sample_valid   = m_tuser[1];
                got.write_addr     = m_tdata[7:0];
                got.write_byte     = m_tdata[15:8];
                got.sample_channel = m_tdata[17:16];
                got.sample_value   = m_tdata[35:18];
                got.query_value    = m_tdata[53:36];
                if (due_results.size() == 0) begin
                    $display("%0t: result with nothing expected: expected none, actual %h/%h",
                             $time, m_tuser, m_tdata);
                    fail_count++;
                end else begin
                    want = due_results.pop_front();
                    check_field("write_valid", want.write_valid, got.write_valid);
                    check_field("write_addr", want.write_addr, got.write_addr);
                    check_field("write_byte", want.write_byte, got.write_byte);
                    check_field("sample_valid", want.sample_valid, got.sample_valid);
                    check_field("sample_channel", want.sample_channel, got.sample_channel);
                    check_field("sample_value", want.sample_value, got.sample_value);
                    check_field("query_value", want.query_value, got.query_value);
                end
                check_field("tdata pad", 0, m_tdata[M_TDATA_W-1:54]);
            end
            if (s_tvalid && s_tready)
                due_results.push_back(decode_and_scan(s_tuser[0], s_tuser[1],
                                                      s_tdata[7:0], s_tdata[15:8],
                                                      s_tdata[23:16], s_tdata[31:24],
                                                      s_tdata[33:32]));
        end
    end

    // Count of results still awaited, updated after each edge
    always @(posedge aclk) begin
        if (!aresetn)
            outstanding <= 0;
        else
            outstanding <= outstanding + int'(s_tvalid && s_tready) - int'(m_tvalid && m_tready);
    end

endmodule

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the ADC scan frame decoder
// Runs a directed set of frames across all resolutions, then random start
// and read transactions over several register settings and idle patterns.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
    import asfd_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int PHASE_ITEMS = 175;

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    cfg_index_t           cfg_index = REG_DATA_FORMAT;
    logic [1:0]           cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic [S_TUSER_W-1:0] s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    int           fail_count;
    int           outstanding;
    int           quiet_cycles = 0;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    data_format_t cur_fmt = FMT_12BIT;

    adc_scan_frame_decoder DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    asfd_checker scan_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Receiver backpressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog on cycles with no transaction on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // One input transaction, with random idle cycles ahead of it
    task automatic send_frame(logic req, logic ok, logic [7:0] b0, logic [7:0] b1,
                              logic [7:0] b2, logic [7:0] b3, chan_t q);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, q, b3, b2, b1, b0};
        s_tuser  <= {ok, req};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Stop sending until every awaited result has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding > 0) @(posedge aclk);
    endtask

    // Write every register, spare index included
    task automatic apply_config(data_format_t fmt, logic [1:0] gain, logic [1:0] id);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_DATA_FORMAT;
        cfg_wdata <= fmt;
        @(posedge aclk);
        cfg_index <= REG_GAIN_SEL;
        cfg_wdata <= gain;
        @(posedge aclk);
        cfg_index <= REG_DEVICE_ID;
        cfg_wdata <= id;
        @(posedge aclk);
        cfg_index <= REG_UNUSED;
        cfg_wdata <= 2'($urandom);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cur_fmt = fmt;
    endtask

    // Mostly finished conversions; some starts, failed reads and busy status
    task automatic random_frame();
        logic [7:0] b0, b1, b2, b3, status;
        logic       req, ok;
        int         pick;
        b0 = 8'($urandom);
        b1 = 8'($urandom);
        b2 = 8'($urandom);
        b3 = 8'($urandom);
        status = {($urandom_range(99) < 25), 2'($urandom_range(3)), 5'($urandom)};
        if (cur_fmt == FMT_18BIT)
            b3 = status;
        else
            b2 = status;
        pick = $urandom_range(99);
        req  = (pick < 5) ? REQ_START : REQ_READ;
        ok   = (req == REQ_START) ? 1'($urandom) : (pick >= 13);
        send_frame(req, ok, b0, b1, b2, b3, 2'($urandom));
    endtask

    initial begin
        int phase_fmt  [8] = '{0, 1, 2, 3, 3, 0, 2, 1};
        int phase_gain [8] = '{0, 3, 1, 2, 3, 0, 2, 1};
        int phase_id   [8] = '{3, 0, 2, 1, 3, 0, 1, 2};
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: 12-bit at reset settings, read before any start
        send_frame(REQ_READ,  1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 2'd0);
        send_frame(REQ_START, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 2'd3);
        send_frame(REQ_READ,  1'b1, 8'h07, 8'hFF, 8'h20, 8'h00, 2'd1);
        send_frame(REQ_READ,  1'b1, 8'hF8, 8'h00, 8'h40, 8'hFF, 2'd2);
        // failed read, then a busy conversion
        send_frame(REQ_READ,  1'b0, 8'hFF, 8'hFF, 8'h00, 8'hFF, 2'd1);
        send_frame(REQ_READ,  1'b1, 8'h0F, 8'hFF, 8'hE0, 8'h00, 2'd3);
        // channel 3 then channel 0: scan wraps around
        send_frame(REQ_READ,  1'b1, 8'hFF, 8'hFF, 8'h7F, 8'hFF, 2'd3);
        send_frame(REQ_READ,  1'b1, 8'h12, 8'h34, 8'h00, 8'h00, 2'd0);
        send_frame(REQ_START, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 2'd2);
        drain();

        // Directed: 18-bit, status in the fourth byte
        apply_config(FMT_18BIT, 2'd3, 2'd3);
        send_frame(REQ_READ, 1'b1, 8'h01, 8'hFF, 8'hFF, 8'h00, 2'd0);
        send_frame(REQ_READ, 1'b1, 8'hFE, 8'h00, 8'h00, 8'h20, 2'd1);
        send_frame(REQ_READ, 1'b1, 8'h00, 8'h00, 8'h00, 8'h80, 2'd2);
        send_frame(REQ_READ, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 2'd3);
        send_frame(REQ_READ, 1'b1, 8'h00, 8'h01, 8'h60, 8'h40, 2'd2);
        drain();

        // Directed: 14-bit and 16-bit extremes
        apply_config(FMT_14BIT, 2'd1, 2'd1);
        send_frame(REQ_READ, 1'b1, 8'h1F, 8'hFF, 8'h00, 8'hAA, 2'd0);
        send_frame(REQ_READ, 1'b1, 8'hE0, 8'h00, 8'h20, 8'h55, 2'd1);
        drain();
        apply_config(FMT_16BIT, 2'd2, 2'd2);
        send_frame(REQ_READ, 1'b1, 8'h7F, 8'hFF, 8'h40, 8'h00, 2'd2);
        send_frame(REQ_READ, 1'b1, 8'h80, 8'h00, 8'h60, 8'hFF, 2'd3);
        drain();

        // Random phases: one register setting and idle pattern each
        for (int p = 0; p < 8; p++) begin
            apply_config(data_format_t'(phase_fmt[p]), 2'(phase_gain[p]), 2'(phase_id[p]));
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
                default: begin send_idle_pct = 10; recv_stall_pct = 10; end
            endcase
            repeat (PHASE_ITEMS) begin
                random_frame();
                if ($urandom_range(49) == 0) drain();
            end
            drain();
        end

        repeat (8) @(posedge aclk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
